### rtl/core/bxr_pkg.sv
// ----------------------------------------------------------------------------
// bxr_pkg
// Shared types and constants of the box range search block: sizes, request
// and result payloads, queue entry, configuration set and back-end states.
// ----------------------------------------------------------------------------
package bxr_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int MAX_DIMS    = 16;
	localparam int COORD_BITS  = 32;

	localparam int POINT_W     = $clog2(MAX_POINTS);
	localparam int DIM_W       = $clog2(MAX_DIMS);
	localparam int NP_W        = $clog2(MAX_POINTS + 1);
	localparam int ND_W        = $clog2(MAX_DIMS + 1);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int PTS_CFG_W   = 7;
	localparam int DIMS_CFG_W  = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_BASE_WR  = 2'd0,
		REQ_QUERY_WR = 2'd1,
		REQ_SEARCH   = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_MODE = 2'd0,
		CFG_POINTS     = 2'd1,
		CFG_DIMS       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         point_index;
		logic [3:0]         dim_index;
		logic signed [31:0] coord_value;
		logic signed [31:0] range_value;
		logic               dim_active;
	} request_t;

	typedef struct packed {
		logic [5:0] match_index;
		logic       has_match;
		logic       last;
	} result_t;

	typedef struct packed {
		logic                  range_mode;
		logic [PTS_CFG_W-1:0]  points;
		logic [DIMS_CFG_W-1:0] dims;
	} cfg_t;

	typedef struct packed {
		req_type_t                 op;
		logic [POINT_W-1:0]        point;
		logic [DIM_W-1:0]          dim;
		logic [COORD_BITS-1:0]     coord;
		logic [COORD_BITS-1:0]     range;
		logic                      active;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_DRAIN
	} back_state_t;

endpackage

### rtl/core/bxr_front.sv
// ----------------------------------------------------------------------------
// bxr_front
// Front end: holds the configuration registers, accepts requests and
// classifies them into queue entries; unknown request codes are dropped.
// ----------------------------------------------------------------------------
module bxr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bxr_pkg::request_t               request,
	input  logic                            cfg_we,
	input  logic [bxr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bxr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  bxr_pkg::queue_status_t          q_status,
	output logic                            push,
	output bxr_pkg::item_t                  push_item,
	output bxr_pkg::cfg_t                   cfg
);
	import bxr_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic known;

	assign busy   = q_status.full;
	assign accept = start && !q_status.full;
	assign push   = accept && known;
	assign cfg    = cfg_q;

	always_comb begin
		unique case (request.req_type) inside
			REQ_BASE_WR, REQ_QUERY_WR, REQ_SEARCH: known = 1'b1;
			default:                               known = 1'b0;
		endcase
	end

	always_comb begin
		push_item.op     = req_type_t'(request.req_type);
		push_item.point  = POINT_W'(request.point_index);
		push_item.dim    = DIM_W'(request.dim_index);
		push_item.coord  = COORD_BITS'(request.coord_value);
		push_item.range  = COORD_BITS'(request.range_value);
		push_item.active = request.dim_active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_mode <= 1'b0;
			cfg_q.points     <= PTS_CFG_W'(MAX_POINTS);
			cfg_q.dims       <= DIMS_CFG_W'(MAX_DIMS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_MODE: cfg_q.range_mode <= cfg_data[0];
				CFG_POINTS:     cfg_q.points     <= PTS_CFG_W'(cfg_data);
				CFG_DIMS:       cfg_q.dims       <= DIMS_CFG_W'(cfg_data);
				default:        ;
			endcase
		end
	end

endmodule

### rtl/core/bxr_queue.sv
// ----------------------------------------------------------------------------
// bxr_queue
// Short first-in first-out queue of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
module bxr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bxr_pkg::item_t         push_item,
	input  logic                   pop,
	output bxr_pkg::item_t         head,
	output bxr_pkg::queue_status_t status
);
	import bxr_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

### rtl/core/bxr_back.sv
// ----------------------------------------------------------------------------
// bxr_back
// Back end: executes queued requests. Writes update the base point memory or
// the query registers; a search walks one base point row per cycle through a
// read, difference and compare pipeline and emits the matching indices.
// ----------------------------------------------------------------------------
module bxr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bxr_pkg::cfg_t          cfg,
	input  bxr_pkg::item_t         head,
	input  bxr_pkg::queue_status_t q_status,
	output logic                   pop,
	output bxr_pkg::result_t       result,
	output logic                   result_strobe
);
	import bxr_pkg::*;

	localparam int CB = COORD_BITS;

	back_state_t state_q;
	back_state_t state_d;

	logic [2*CB-1:0]    base_mem_q [MAX_POINTS][MAX_DIMS];
	logic [CB-1:0]      q_coord_q [MAX_DIMS];
	logic [CB-1:0]      q_range_q [MAX_DIMS];
	logic [MAX_DIMS-1:0] q_active_q;

	logic [NP_W-1:0]    addr_q;
	logic [NP_W-1:0]    np_q;
	logic [ND_W-1:0]    nd_q;
	logic               mode_q;

	logic [2*CB-1:0]    row_s1 [MAX_DIMS];
	logic [POINT_W-1:0] idx_s1;
	logic               vld_s1;

	logic signed [CB:0]   diff_s2 [MAX_DIMS];
	logic signed [CB-1:0] rng_s2 [MAX_DIMS];
	logic [MAX_DIMS-1:0]  chk_s2;
	logic [POINT_W-1:0]   idx_s2;
	logic                 vld_s2;

	logic               held_vld_q;
	logic [POINT_W-1:0] held_idx_q;
	result_t            result_q;
	logic               strobe_q;

	logic                issue;
	logic                finish;
	logic                start_search;
	logic [MAX_DIMS-1:0] dim_ok;
	logic                hit;
	logic [NP_W-1:0]     np_sat;
	logic [ND_W-1:0]     nd_sat;

	assign np_sat = (cfg.points > PTS_CFG_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS)
	                                                      : NP_W'(cfg.points);
	assign nd_sat = (cfg.dims > DIMS_CFG_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS)
	                                                   : ND_W'(cfg.dims);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty && head.op == REQ_SEARCH)
					state_d = BK_WALK;
			end
			BK_WALK: begin
				if (addr_q >= np_q)
					state_d = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (!vld_s1 && !vld_s2)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		issue  = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			BK_IDLE:  pop    = !q_status.empty;
			BK_WALK:  issue  = (addr_q < np_q);
			BK_DRAIN: finish = !vld_s1 && !vld_s2;
			default:  ;
		endcase
	end

	assign start_search = pop && head.op == REQ_SEARCH;

	always_comb begin
		logic signed [CB:0] r_ext;
		for (int d = 0; d < MAX_DIMS; d++) begin
			r_ext     = {rng_s2[d][CB-1], rng_s2[d]};
			dim_ok[d] = !chk_s2[d] || (diff_s2[d] <= r_ext && diff_s2[d] >= -r_ext);
		end
	end

	assign hit = vld_s2 && (&dim_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			q_active_q <= '1;
			addr_q     <= '0;
			np_q       <= '0;
			nd_q       <= '0;
			mode_q     <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			held_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			vld_s1   <= issue;
			vld_s2   <= vld_s1;
			strobe_q <= 1'b0;
			if (pop && head.op == REQ_QUERY_WR)
				q_active_q[head.dim] <= head.active;
			if (start_search) begin
				addr_q     <= '0;
				np_q       <= np_sat;
				nd_q       <= nd_sat;
				mode_q     <= cfg.range_mode;
				held_vld_q <= 1'b0;
			end
			if (issue)
				addr_q <= addr_q + 1'b1;
			if (hit) begin
				held_vld_q <= 1'b1;
				strobe_q   <= held_vld_q;
			end
			if (finish) begin
				held_vld_q <= 1'b0;
				strobe_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.op)
				REQ_BASE_WR:  base_mem_q[head.point][head.dim] <= {head.coord, head.range};
				REQ_QUERY_WR: begin
					q_coord_q[head.dim] <= head.coord;
					q_range_q[head.dim] <= head.range;
				end
				default: ;
			endcase
		end
		if (issue) begin
			row_s1 <= base_mem_q[addr_q[POINT_W-1:0]];
			idx_s1 <= addr_q[POINT_W-1:0];
		end
		for (int d = 0; d < MAX_DIMS; d++) begin
			diff_s2[d] <= $signed({row_s1[d][2*CB-1], row_s1[d][2*CB-1:CB]})
			            - $signed({q_coord_q[d][CB-1], q_coord_q[d]});
			rng_s2[d]  <= mode_q ? $signed(row_s1[d][CB-1:0]) : $signed(q_range_q[d]);
			chk_s2[d]  <= q_active_q[d] && (ND_W'(d) < nd_q);
		end
		idx_s2 <= idx_s1;
		if (hit) begin
			held_idx_q           <= idx_s2;
			result_q.match_index <= 6'(held_idx_q);
			result_q.has_match   <= 1'b1;
			result_q.last        <= 1'b0;
		end
		if (finish) begin
			result_q.match_index <= held_vld_q ? 6'(held_idx_q) : '0;
			result_q.has_match   <= held_vld_q;
			result_q.last        <= 1'b1;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

### rtl/core/box_range_search.sv
// ----------------------------------------------------------------------------
// box_range_search
// Brute-force box range search over a table of base points against one held
// query, with per-query or per-point half-widths and active dimensions.
//
//   port group      direction  handshake            payload
//   request         in         start / busy         request_t
//   configuration   in         cfg_we               cfg_index, cfg_data
//   result          out        result_strobe        result_t
//
// A request is taken when start is high and busy low; busy rises only while
// the two-entry request queue is full. A write is done as the back end pops it.
// A search holds the back end through a pop, a walk over its points and a
// drain of the read and difference stages; its final result is registered
// as the drain ends. Results leave one per cycle on result_strobe and cannot
// be held off. Reset clears control state and sets every query dimension
// active; the point memory has no clearing pass.
// ----------------------------------------------------------------------------
module box_range_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bxr_pkg::request_t               request,
	input  logic                            cfg_we,
	input  logic [bxr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bxr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bxr_pkg::result_t                result,
	output logic                            result_strobe
);
	import bxr_pkg::*;

	cfg_t          cfg;
	queue_status_t q_status;
	item_t         push_item;
	item_t         head;
	logic          push;
	logic          pop;

	bxr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item),
		.cfg       (cfg)
	);

	bxr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	bxr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.result        (result),
		.result_strobe (result_strobe)
	);

`ifndef SYNTH
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.has_match |-> result.last && result.match_index == '0)
		else $error("empty result not final or index not zero");

	a_index_rises: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last ##1 result_strobe
		|-> result.match_index > $past(result.match_index))
		else $error("match indices out of order");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("result right after final result");
`endif

endmodule
